>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define QDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define QDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/qdd_pkg.sv
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared types and codes for the quadrature detent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qdd_pkg;

  // Item kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  // Fixed payload widths of the channels
  localparam int unsigned POS_W = 32;

  typedef logic signed [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

>>> design/qdd_stream_if.sv
// ----------------------------------------------------------------------------
// qdd stream interfaces
// Valid/ready channels for sample/load beats in and position beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface qdd_in_if
  import qdd_pkg::*;
  ();
  logic valid;
  logic ready;
  logic kind;
  logic line_a;
  logic line_b;
  pos_t load_value;

  modport source (output valid, output kind, output line_a, output line_b,
                  output load_value, input ready);
  modport sink   (input valid, input kind, input line_a, input line_b,
                  input load_value, output ready);
endinterface

interface qdd_out_if
  import qdd_pkg::*;
  ();
  logic valid;
  logic ready;
  pos_t position;
  logic moved_up;
  logic moved_down;

  modport source (output valid, output position, output moved_up,
                  output moved_down, input ready);
  modport sink   (input valid, input position, input moved_up,
                  input moved_down, output ready);
endinterface

`default_nettype wire

>>> design/quadrature_detent_decoder_core.sv
// ----------------------------------------------------------------------------
// quadrature_detent_decoder_core
// Rotary encoder decoder with detent tracking, glitch rejection and preset.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per encoder sample (kind = sample, line_a/line_b) or
//            per preset (kind = load, load_value).
//   out_ch : exactly one beat per input beat: position after the beat and
//            the moved_up / moved_down flags.
//   The phase machine and counter update on the accepting edge and the
//   result lands in the output register.
//   Throughput is one beat per cycle while the receiver keeps up; the
//   output register is the only stage, so in_ch.ready is high whenever
//   that register is empty or is being drained in the same cycle.
//   When the receiver stalls, the result holds and in_ch.ready drops until
//   it is taken; no beat is lost.
//   Reset (rst_n low, synchronous) returns the phase to the idle detent,
//   clears the count and empties the output register.
//   The count is COUNT_WIDTH bits and wraps; position is the count
//   sign-extended or truncated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module quadrature_detent_decoder_core
  import qdd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire       clk,
  input  wire       rst_n,
  qdd_in_if.sink    in_ch,
  qdd_out_if.source out_ch
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CW1  = 3'd1;
  localparam logic [2:0] PH_CW2  = 3'd2;
  localparam logic [2:0] PH_CW3  = 3'd3;
  localparam logic [2:0] PH_CCW1 = 3'd4;
  localparam logic [2:0] PH_CCW2 = 3'd5;
  localparam logic [2:0] PH_CCW3 = 3'd6;

  typedef logic signed [COUNT_WIDTH-1:0] count_t;

  logic [2:0] phase_r, phase_nxt;
  count_t     count_r, count_nxt;
  logic       up_nxt, down_nxt;

  logic       out_valid_r;
  pos_t       position_r;
  logic       moved_up_r, moved_down_r;

  logic       in_acc;
  logic       a, b;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign a           = in_ch.line_a;
  assign b           = in_ch.line_b;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    up_nxt    = 1'b0;
    down_nxt  = 1'b0;
    if (in_ch.kind == KIND_LOAD) begin
      count_nxt = COUNT_WIDTH'(in_ch.load_value);
    end else begin
      case (phase_r)
        PH_CW1: begin
          if (!b) begin
            if (!a) begin
              count_nxt = count_r + COUNT_WIDTH'(1);
              up_nxt    = 1'b1;
              phase_nxt = PH_CW2;
            end
          end else if (a) begin
            // first line back high before the second fell: glitch
            phase_nxt = PH_IDLE;
          end
        end
        PH_CW2: begin
          if (b) phase_nxt = PH_CW3;
        end
        PH_CW3: begin
          if (a) phase_nxt = PH_IDLE;
        end
        PH_CCW1: begin
          if (!a) begin
            if (!b) begin
              count_nxt = count_r - COUNT_WIDTH'(1);
              down_nxt  = 1'b1;
              phase_nxt = PH_CCW2;
            end
          end else if (b) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_CCW2: begin
          if (a) phase_nxt = PH_CCW3;
        end
        PH_CCW3: begin
          if (b) phase_nxt = PH_IDLE;
        end
        default: begin
          // A falling wins over B falling at the detent
          if (!a) begin
            phase_nxt = PH_CCW1;
          end else if (!b) begin
            phase_nxt = PH_CW1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: load on each accepted beat, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      position_r   <= POS_W'(count_nxt);
      moved_up_r   <= up_nxt;
      moved_down_r <= down_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.position   = position_r;
  assign out_ch.moved_up   = moved_up_r;
  assign out_ch.moved_down = moved_down_r;

  `QDD_ASSERT(a_no_both_moves, out_valid_r |-> !(moved_up_r && moved_down_r),
              "result flags both up and down")
  `QDD_ASSERT(a_load_keeps_phase, (in_acc && in_ch.kind == KIND_LOAD) |=> $stable(phase_r),
              "load beat changed the decode phase")
  `QDD_ASSERT(a_up_counts, (in_acc && up_nxt) |=> count_r == $past(count_r) + COUNT_WIDTH'(1),
              "up move did not increment the count")
  `QDD_ASSERT(a_down_from_ccw1, (in_acc && down_nxt) |-> phase_r == PH_CCW1,
              "down move outside the first counter-clockwise phase")
  `QDD_ASSERT(a_stall_blocks_input, (out_valid_r && !out_ch.ready) |-> !in_ch.ready,
              "input taken while result is stalled")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the quadrature detent decoder: a directed sequence
// covers clockwise and counter-clockwise turns, both kinds of glitch, both
// lines falling together at the detent, presets, and count wrap at both
// ends. Random turns, glitches, noise and presets follow. Each position
// beat is compared against a cycle-free model of the phase machine and
// counter, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import qdd_pkg::*;

  localparam int unsigned COUNT_W  = 32;
  localparam int          N_RANDOM = 1600;
  localparam int          STUCK_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_DETENT      = 3'd0,
    PH_CW_B_LOW    = 3'd1,
    PH_CW_COUNTED  = 3'd2,
    PH_CW_B_HIGH   = 3'd3,
    PH_CCW_A_LOW   = 3'd4,
    PH_CCW_COUNTED = 3'd5,
    PH_CCW_A_HIGH  = 3'd6
  } turn_phase_t;

  typedef struct packed {
    logic kind;
    logic line_a;
    logic line_b;
    pos_t load_value;
  } enc_item_t;

  typedef struct packed {
    pos_t position;
    logic moved_up;
    logic moved_down;
  } enc_report_t;

  logic clk;
  logic rst_n;

  qdd_in_if  in_ch_if ();
  qdd_out_if out_ch_if ();

  quadrature_detent_decoder_core #(
    .COUNT_WIDTH(COUNT_W)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch_if.sink),
    .out_ch(out_ch_if.source)
  );

  enc_item_t        sample_q[$];
  enc_report_t      due_reports[$];
  turn_phase_t      turn_phase;
  logic [COUNT_W-1:0] turn_count;
  int               mismatches;
  int               stuck_cycles;
  bit               in_taken;
  bit               in_calm;
  bit               out_calm;
  int               in_gap;
  int               out_hold;
  enc_item_t        next_item;

  // Model of the phase machine; updates turn_phase and turn_count.
  function automatic enc_report_t decode_step(enc_item_t it);
    enc_report_t r;
    r.moved_up   = 1'b0;
    r.moved_down = 1'b0;
    if (it.kind == KIND_LOAD) begin
      turn_count = COUNT_W'(it.load_value);
    end else begin
      case (turn_phase)
        PH_CW_B_LOW: begin
          if (!it.line_b) begin
            if (!it.line_a) begin
              turn_count = turn_count + COUNT_W'(1);
              r.moved_up = 1'b1;
              turn_phase = PH_CW_COUNTED;
            end
          end else if (it.line_a) begin
            turn_phase = PH_DETENT;
          end
        end
        PH_CW_COUNTED: if (it.line_b) turn_phase = PH_CW_B_HIGH;
        PH_CW_B_HIGH:  if (it.line_a) turn_phase = PH_DETENT;
        PH_CCW_A_LOW: begin
          if (!it.line_a) begin
            if (!it.line_b) begin
              turn_count = turn_count - COUNT_W'(1);
              r.moved_down = 1'b1;
              turn_phase = PH_CCW_COUNTED;
            end
          end else if (it.line_b) begin
            turn_phase = PH_DETENT;
          end
        end
        PH_CCW_COUNTED: if (it.line_a) turn_phase = PH_CCW_A_HIGH;
        PH_CCW_A_HIGH:  if (it.line_b) turn_phase = PH_DETENT;
        default: begin
          // line A wins when both fall together
          if (!it.line_a)      turn_phase = PH_CCW_A_LOW;
          else if (!it.line_b) turn_phase = PH_CW_B_LOW;
          else                 turn_phase = PH_DETENT;
        end
      endcase
    end
    r.position = pos_t'($signed(turn_count));
    return r;
  endfunction

  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic push_sample(logic a, logic b);
    enc_item_t it;
    it.kind       = KIND_SAMPLE;
    it.line_a     = a;
    it.line_b     = b;
    it.load_value = pos_t'($urandom);
    sample_q.push_back(it);
  endtask

  task automatic push_load(pos_t v);
    enc_item_t it;
    it.kind       = KIND_LOAD;
    it.line_a     = 1'($urandom_range(0, 1));
    it.line_b     = 1'($urandom_range(0, 1));
    it.load_value = v;
    sample_q.push_back(it);
  endtask

  // Full quadrature cycle from the detent; each level held 1..reps beats.
  task automatic push_turn(bit cw, int reps);
    logic [1:0] steps [4];
    if (cw) steps = '{2'b10, 2'b00, 2'b01, 2'b11};
    else    steps = '{2'b01, 2'b00, 2'b10, 2'b11};
    foreach (steps[i])
      repeat ($urandom_range(1, reps)) push_sample(steps[i][1], steps[i][0]);
  endtask

  // First line falls, then returns high before the second one falls.
  task automatic push_glitch(bit cw, int reps);
    repeat ($urandom_range(1, reps)) begin
      if (cw) push_sample(1'b1, 1'b0);
      else    push_sample(1'b0, 1'b1);
    end
    push_sample(1'b1, 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: predict on accepted input beats, check accepted output beats.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst_n) begin
      turn_phase   = PH_DETENT;
      turn_count   = '0;
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (out_ch_if.valid && out_ch_if.ready) begin
        stuck_cycles = 0;
        if (due_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, got position %0d up %b down %b",
                   $time, out_ch_if.position, out_ch_if.moved_up, out_ch_if.moved_down);
        end else begin
          enc_report_t exp_r;
          exp_r = due_reports.pop_front();
          if (out_ch_if.position !== exp_r.position) begin
            mismatches++;
            $display("%0t: position expected %0d got %0d",
                     $time, exp_r.position, out_ch_if.position);
          end
          if (out_ch_if.moved_up !== exp_r.moved_up) begin
            mismatches++;
            $display("%0t: moved_up expected %b got %b",
                     $time, exp_r.moved_up, out_ch_if.moved_up);
          end
          if (out_ch_if.moved_down !== exp_r.moved_down) begin
            mismatches++;
            $display("%0t: moved_down expected %b got %b",
                     $time, exp_r.moved_down, out_ch_if.moved_down);
          end
        end
      end
      if (in_ch_if.valid && in_ch_if.ready) begin
        enc_item_t it;
        stuck_cycles = 0;
        in_taken     = 1'b1;
        it.kind       = in_ch_if.kind;
        it.line_a     = in_ch_if.line_a;
        it.line_b     = in_ch_if.line_b;
        it.load_value = in_ch_if.load_value;
        due_reports.push_back(decode_step(it));
      end
    end
  end

  // Driver: advance to the next beat once the current one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
      if (!in_ch_if.valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch_if.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          next_item = sample_q.pop_front();
          in_ch_if.kind       <= next_item.kind;
          in_ch_if.line_a     <= next_item.line_a;
          in_ch_if.line_b     <= next_item.line_b;
          in_ch_if.load_value <= next_item.load_value;
          in_ch_if.valid      <= 1'b1;
          in_gap = pick_gap(in_calm);
        end else begin
          in_ch_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, with calm stretches.
  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (out_hold > 0) begin
        out_hold--;
        out_ch_if.ready <= 1'b0;
      end else begin
        out_ch_if.ready <= 1'b1;
        out_hold = pick_gap(out_calm);
      end
    end
  end

  initial begin
    int   roll;
    pos_t v;
    mismatches = 0;
    in_gap     = 0;
    out_hold   = 0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    in_taken   = 1'b0;
    rst_n      = 1'b0;
    in_ch_if.valid      = 1'b0;
    in_ch_if.kind       = KIND_SAMPLE;
    in_ch_if.line_a     = 1'b1;
    in_ch_if.line_b     = 1'b1;
    in_ch_if.load_value = '0;
    out_ch_if.ready     = 1'b0;

    // Directed: both directions, both glitches, both lines low at detent,
    // wrap at both ends, preset in the middle of a turn.
    push_turn(1'b1, 1);
    push_turn(1'b0, 1);
    push_glitch(1'b1, 1);
    push_glitch(1'b0, 1);
    push_sample(1'b0, 1'b0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b1);
    push_load(32'sh7FFF_FFFF);
    push_turn(1'b1, 1);
    push_sample(1'b0, 1'b1);
    push_sample(1'b0, 1'b0);
    push_load(-32'sd1);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b1);
    push_load('0);

    // Random: mostly clean turns, some glitches, noise and presets.
    while (sample_q.size() < N_RANDOM) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        push_turn(1'($urandom_range(0, 1)), $urandom_range(1, 3));
      end else if (roll < 80) begin
        push_glitch(1'($urandom_range(0, 1)), 2);
      end else if (roll < 92) begin
        repeat ($urandom_range(1, 4))
          push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 3))
          0:       v = pos_t'($urandom);
          1:       v = 32'sh7FFF_FFFF - pos_t'($urandom_range(0, 2));
          2:       v = 32'sh8000_0000 + pos_t'($urandom_range(0, 2));
          default: v = pos_t'($urandom_range(0, 4)) - 32'sd2;
        endcase
        push_load(v);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while ((sample_q.size() != 0 || in_ch_if.valid || due_reports.size() != 0)
           && stuck_cycles < STUCK_LIMIT)
      @(negedge clk);

    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
    end else begin
      // keep watching the output to catch any stray beat
      repeat (4) @(negedge clk);
      if (mismatches == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/qdd_pkg.sv
design/qdd_stream_if.sv
design/quadrature_detent_decoder_core.sv
tb/sv/tb_top.sv
